>>> design/bvsg_pkg.sv
`default_nettype none

package bvsg_pkg;

    // window length in samples, 2 to 64
    localparam int SAMPLES_PER_WINDOW = 16;

    // converter code to millivolts: (code * 700) >> 9
    localparam int CODE_W     = 12;
    localparam int MV_SCALE   = 700;
    localparam int MV_SHIFT   = 9;
    localparam int MV_PROD_W  = CODE_W + $clog2(MV_SCALE);
    localparam int MV_MAX     = ((2 ** CODE_W - 1) * MV_SCALE) >> MV_SHIFT;
    localparam int MV_W       = 13;

    localparam int SUM_W      = $clog2(MV_MAX * SAMPLES_PER_WINDOW + 1);
    localparam int CNT_W      = $clog2(SAMPLES_PER_WINDOW);
    localparam int DROP_W     = 8;
    localparam int PCT_W      = 7;
    localparam int FULL_PCT   = 100;

    // blend weights: (sleep*7 + active*3) / 10
    localparam int SLP_WEIGHT = 7;
    localparam int ACT_WEIGHT = 3;
    localparam int WEIGHT_SUM = SLP_WEIGHT + ACT_WEIGHT;

    // constant divide by reciprocal multiply, exact over the numerator range
    localparam int NUM_W       = $clog2(WEIGHT_SUM * MV_MAX * SAMPLES_PER_WINDOW + 1);
    localparam int DIV_ACT     = SAMPLES_PER_WINDOW;
    localparam int DIV_BLEND   = WEIGHT_SUM * SAMPLES_PER_WINDOW;
    localparam int RECIP_SHIFT = NUM_W + $clog2(DIV_BLEND);
    localparam int RECIP_W     = RECIP_SHIFT;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam longint unsigned RECIP_ACT =
        ((64'd1 << RECIP_SHIFT) + 64'(DIV_ACT) - 64'd1) / 64'(DIV_ACT);
    localparam longint unsigned RECIP_BLEND =
        ((64'd1 << RECIP_SHIFT) + 64'(DIV_BLEND) - 64'd1) / 64'(DIV_BLEND);

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // voltage to percent, entry i gives 100 - i
    localparam int TABLE_LEN = 101;
    localparam logic [MV_W-1:0] VOLT_TABLE [0:TABLE_LEN-1] = '{
        13'd4170, 13'd4154, 13'd4136, 13'd4122, 13'd4107, 13'd4102, 13'd4088, 13'd4081,
        13'd4070, 13'd4060, 13'd4053, 13'd4044, 13'd4035, 13'd4028, 13'd4019, 13'd4013,
        13'd4006, 13'd3995, 13'd3987, 13'd3982, 13'd3976, 13'd3968, 13'd3962, 13'd3954,
        13'd3946, 13'd3941, 13'd3934, 13'd3929, 13'd3922, 13'd3916, 13'd3910, 13'd3904,
        13'd3898, 13'd3892, 13'd3887, 13'd3880, 13'd3874, 13'd3868, 13'd3862, 13'd3854,
        13'd3849, 13'd3843, 13'd3840, 13'd3833, 13'd3829, 13'd3824, 13'd3818, 13'd3815,
        13'd3810, 13'd3808, 13'd3804, 13'd3801, 13'd3798, 13'd3796, 13'd3792, 13'd3789,
        13'd3785, 13'd3784, 13'd3782, 13'd3780, 13'd3777, 13'd3776, 13'd3774, 13'd3772,
        13'd3771, 13'd3769, 13'd3768, 13'd3764, 13'd3763, 13'd3760, 13'd3760, 13'd3754,
        13'd3750, 13'd3749, 13'd3744, 13'd3740, 13'd3734, 13'd3732, 13'd3728, 13'd3726,
        13'd3720, 13'd3716, 13'd3709, 13'd3703, 13'd3698, 13'd3692, 13'd3683, 13'd3675,
        13'd3670, 13'd3665, 13'd3661, 13'd3657, 13'd3649, 13'd3637, 13'd3622, 13'd3609,
        13'd3580, 13'd3558, 13'd3540, 13'd3510, 13'd3429
    };

    typedef struct packed {
        logic [CODE_W-1:0] sample_code;
        logic              sample_is_sleep;
        logic              charger_online;
    } sample_t;

    typedef struct packed {
        logic [MV_W-1:0]   avg_voltage_mv;
        logic [PCT_W-1:0]  table_percent;
        logic [PCT_W-1:0]  reported_percent;
        logic              battery_full;
        logic              used_sleep_samples;
        logic [DROP_W-1:0] dropped_samples;
    } result_t;

    // one closed window on its way to the back end
    typedef struct packed {
        logic [SUM_W-1:0]  active_sum;
        logic [SUM_W-1:0]  sleep_sum;
        logic              used_sleep;
        logic [DROP_W-1:0] drops;
    } win_t;

    // queue write side
    typedef struct packed {
        logic push;
        win_t data;
    } q_wr_t;

    // queue read side
    typedef struct packed {
        logic valid;
        win_t data;
    } q_rd_t;

endpackage

`default_nettype wire

>>> design/bvsg_front.sv
`default_nettype none

module bvsg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  bvsg_pkg::sample_t sample,
    input  logic              q_full,
    output bvsg_pkg::q_wr_t   q_wr
);

    logic [bvsg_pkg::SUM_W-1:0]  act_sum_reg, act_sum_next;
    logic [bvsg_pkg::SUM_W-1:0]  slp_sum_reg, slp_sum_next;
    logic [bvsg_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        phase_reg, phase_next;
    logic [bvsg_pkg::DROP_W-1:0] drop_reg, drop_next;

    logic [bvsg_pkg::MV_PROD_W-1:0] mv_prod;
    logic [bvsg_pkg::MV_W-1:0]      mv;
    logic [bvsg_pkg::SUM_W-1:0]     act_sum_inc;
    logic [bvsg_pkg::SUM_W-1:0]     slp_sum_inc;
    logic                           accept;
    logic                           last_beat;
    logic                           push;

    // code to millivolts
    assign mv_prod = bvsg_pkg::MV_PROD_W'(sample.sample_code)
                   * bvsg_pkg::MV_PROD_W'(bvsg_pkg::MV_SCALE);
    assign mv      = bvsg_pkg::MV_W'(mv_prod >> bvsg_pkg::MV_SHIFT);

    assign act_sum_inc = act_sum_reg + bvsg_pkg::SUM_W'(mv);
    assign slp_sum_inc = slp_sum_reg + bvsg_pkg::SUM_W'(mv);

    assign sample_ready = !q_full;
    assign accept       = sample_valid && sample_ready;
    assign last_beat    = (cnt_reg == bvsg_pkg::CNT_W'(bvsg_pkg::SAMPLES_PER_WINDOW - 1));

    // window record as it would be pushed on this beat
    assign q_wr.push            = push;
    assign q_wr.data.active_sum = phase_reg ? act_sum_reg : act_sum_inc;
    assign q_wr.data.sleep_sum  = slp_sum_inc;
    assign q_wr.data.used_sleep = phase_reg;
    assign q_wr.data.drops      = drop_reg;

    // accumulate, classify and close windows
    always_comb
    begin
        act_sum_next = act_sum_reg;
        slp_sum_next = slp_sum_reg;
        cnt_next     = cnt_reg;
        phase_next   = phase_reg;
        drop_next    = drop_reg;
        push         = 1'b0;

        if (accept)
        begin
            if (sample.sample_is_sleep != phase_reg)
            begin
                // wrong phase: only counted
                if (drop_reg != '1)
                begin
                    drop_next = drop_reg + 1'b1;
                end
            end
            else if (!last_beat)
            begin
                cnt_next = cnt_reg + 1'b1;
                if (phase_reg)
                begin
                    slp_sum_next = slp_sum_inc;
                end
                else
                begin
                    act_sum_next = act_sum_inc;
                end
            end
            else if (!phase_reg && !sample.charger_online)
            begin
                // active window done, go on to sleep samples
                act_sum_next = act_sum_inc;
                cnt_next     = '0;
                phase_next   = 1'b1;
            end
            else
            begin
                // window closes
                push         = 1'b1;
                act_sum_next = '0;
                slp_sum_next = '0;
                cnt_next     = '0;
                phase_next   = 1'b0;
                drop_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_sum_reg <= '0;
            slp_sum_reg <= '0;
            cnt_reg     <= '0;
            phase_reg   <= 1'b0;
            drop_reg    <= '0;
        end
        else
        begin
            act_sum_reg <= act_sum_next;
            slp_sum_reg <= slp_sum_next;
            cnt_reg     <= cnt_next;
            phase_reg   <= phase_next;
            drop_reg    <= drop_next;
        end
    end

endmodule

`default_nettype wire

>>> design/bvsg_queue.sv
`default_nettype none

module bvsg_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  bvsg_pkg::q_wr_t q_wr,
    output logic            full,
    output bvsg_pkg::q_rd_t q_rd,
    input  logic            pop
);

    bvsg_pkg::win_t                entry_reg [0:bvsg_pkg::Q_DEPTH-1];
    logic [bvsg_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bvsg_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bvsg_pkg::QCNT_W-1:0]   fill_reg, fill_next;
    logic                          do_push;
    logic                          do_pop;

    assign full       = (fill_reg == bvsg_pkg::QCNT_W'(bvsg_pkg::Q_DEPTH));
    assign q_rd.valid = (fill_reg != '0);
    assign q_rd.data  = entry_reg[rd_ptr_reg];

    assign do_push = q_wr.push && !full;
    assign do_pop  = pop && q_rd.valid;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == bvsg_pkg::QPTR_W'(bvsg_pkg::Q_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == bvsg_pkg::QPTR_W'(bvsg_pkg::Q_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_wr.data;
        end
    end

endmodule

`default_nettype wire

>>> design/bvsg_back.sv
`default_nettype none

module bvsg_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bvsg_pkg::q_rd_t   q_rd,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output bvsg_pkg::result_t result
);

    // coarse reporting buckets
    function automatic logic [bvsg_pkg::PCT_W-1:0] bucket(
        input logic [bvsg_pkg::PCT_W-1:0] p
    );
        logic [bvsg_pkg::PCT_W-1:0] r;
        priority if (p >= 7'd97) r = 7'd100;
        else if (p >= 7'd95)     r = 7'd95;
        else if (p >= 7'd90)     r = 7'd90;
        else if (p >= 7'd80)     r = 7'd85;
        else if (p >= 7'd70)     r = 7'd75;
        else if (p >= 7'd50)     r = 7'd55;
        else if (p >= 7'd30)     r = 7'd35;
        else if (p >= 7'd10)     r = 7'd20;
        else if (p >= 7'd5)      r = 7'd5;
        else                     r = 7'd0;
        return r;
    endfunction

    logic                            en;

    // stage 1: numerator
    logic                            s1_valid_reg, s1_valid_next;
    logic [bvsg_pkg::NUM_W-1:0]      s1_num_reg, s1_num_next;
    logic                            s1_blend_reg;
    logic [bvsg_pkg::DROP_W-1:0]     s1_drops_reg;

    // stage 2: reciprocal product
    logic                            s2_valid_reg;
    logic [bvsg_pkg::PROD_W-1:0]     s2_prod_reg, s2_prod_next;
    logic                            s2_blend_reg;
    logic [bvsg_pkg::DROP_W-1:0]     s2_drops_reg;

    // stage 3: average and table percent
    logic                            s3_valid_reg;
    logic [bvsg_pkg::MV_W-1:0]       s3_avg_reg, s3_avg_next;
    logic [bvsg_pkg::PCT_W-1:0]      s3_pct_reg, s3_pct_next;
    logic                            s3_blend_reg;
    logic [bvsg_pkg::DROP_W-1:0]     s3_drops_reg;

    // output register
    logic                            out_valid_reg;
    bvsg_pkg::result_t               result_reg, result_next;

    logic [bvsg_pkg::RECIP_W-1:0]    recip;
    logic [bvsg_pkg::TABLE_LEN-1:0]  hit;
    logic [bvsg_pkg::PCT_W-1:0]      hit_cnt;

    // whole pipe moves when the output slot is free or being taken
    assign en  = !out_valid_reg || result_ready;
    assign pop = q_rd.valid && en;

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // numerator: active sum, or weighted blend
    always_comb
    begin
        s1_valid_next = q_rd.valid;
        if (q_rd.data.used_sleep)
        begin
            s1_num_next = bvsg_pkg::NUM_W'(q_rd.data.sleep_sum)
                        * bvsg_pkg::NUM_W'(bvsg_pkg::SLP_WEIGHT)
                        + bvsg_pkg::NUM_W'(q_rd.data.active_sum)
                        * bvsg_pkg::NUM_W'(bvsg_pkg::ACT_WEIGHT);
        end
        else
        begin
            s1_num_next = bvsg_pkg::NUM_W'(q_rd.data.active_sum);
        end
    end

    // divide by window length, or by ten times it
    assign recip = s1_blend_reg ? bvsg_pkg::RECIP_W'(bvsg_pkg::RECIP_BLEND)
                                : bvsg_pkg::RECIP_W'(bvsg_pkg::RECIP_ACT);
    assign s2_prod_next = bvsg_pkg::PROD_W'(s1_num_reg) * bvsg_pkg::PROD_W'(recip);

    // table lookup: entries at or below the average, table is non-increasing
    always_comb
    begin
        s3_avg_next = bvsg_pkg::MV_W'(s2_prod_reg >> bvsg_pkg::RECIP_SHIFT);
        for (int i = 0; i < bvsg_pkg::TABLE_LEN; i++)
        begin
            hit[i] = (s3_avg_next >= bvsg_pkg::VOLT_TABLE[i]);
        end
        hit_cnt     = bvsg_pkg::PCT_W'($countones(hit));
        s3_pct_next = (hit_cnt == '0) ? '0 : hit_cnt - 1'b1;
    end

    // bucketing into the result
    always_comb
    begin
        result_next.avg_voltage_mv     = s3_avg_reg;
        result_next.table_percent      = s3_pct_reg;
        result_next.reported_percent   = bucket(s3_pct_reg);
        result_next.battery_full       =
            (result_next.reported_percent == bvsg_pkg::PCT_W'(bvsg_pkg::FULL_PCT));
        result_next.used_sleep_samples = s3_blend_reg;
        result_next.dropped_samples    = s3_drops_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_num_reg   <= s1_num_next;
            s1_blend_reg <= q_rd.data.used_sleep;
            s1_drops_reg <= q_rd.data.drops;
            s2_prod_reg  <= s2_prod_next;
            s2_blend_reg <= s1_blend_reg;
            s2_drops_reg <= s1_drops_reg;
            s3_avg_reg   <= s3_avg_next;
            s3_pct_reg   <= s3_pct_next;
            s3_blend_reg <= s2_blend_reg;
            s3_drops_reg <= s2_drops_reg;
            result_reg   <= result_next;
        end
    end

    // full flag only with the top bucket
    a_full_top: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.battery_full
            |-> result.reported_percent == bvsg_pkg::PCT_W'(bvsg_pkg::FULL_PCT))
        else $error("battery_full without top bucket");

    // below the table bottom the percent is zero
    a_below_table: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.avg_voltage_mv < bvsg_pkg::VOLT_TABLE[bvsg_pkg::TABLE_LEN-1])
            |-> result.table_percent == '0)
        else $error("non-zero percent below table");

    // a stalled pipe keeps its contents
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en && s3_valid_reg |=> s3_valid_reg && $stable(s3_avg_reg))
        else $error("stage 3 lost data under stall");

    // a window is only taken from the queue when the pipe can move
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> s1_valid_reg)
        else $error("popped window did not enter the pipe");

endmodule

`default_nettype wire

>>> design/battery_voltage_soc_gauge.sv
`default_nettype none

// Voltage-based battery gauge. One sample beat is taken every cycle while
// sample_ready is high; sample_ready drops only when the two-entry window
// queue is full. Wrong-phase samples are counted, not summed. The beat that
// closes a window gives one result beat via the queue, numerator,
// reciprocal multiply, table lookup and bucketed output registers. The
// back end takes one window per cycle when not stalled, but a window
// closes at most once per sixteen sample beats, so results come no
// faster than that. Results hold while result_ready is low, and the
// back end stalls as a whole until the output register is taken.
module battery_voltage_soc_gauge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  bvsg_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_ready,
    output bvsg_pkg::result_t result
);

    bvsg_pkg::q_wr_t q_wr;
    bvsg_pkg::q_rd_t q_rd;
    logic            q_full;
    logic            q_pop;

    bvsg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .q_full       (q_full),
        .q_wr         (q_wr)
    );

    bvsg_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .full  (q_full),
        .q_rd  (q_rd),
        .pop   (q_pop)
    );

    bvsg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_rd         (q_rd),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire
